@@ hw/rtl/tpq_pkg.sv @@
// Shared types, constants and helpers for the three-class priority queue.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
package tpq_pkg;

  // Entries per class store
  localparam int CLASS_DEPTH = 16;
  localparam int NUM_CLASSES = 3;
  localparam int NUM_SLOTS   = NUM_CLASSES * CLASS_DEPTH;

  localparam int PTR_W   = $clog2(CLASS_DEPTH);
  localparam int CNT_W   = $clog2(CLASS_DEPTH + 1);
  localparam int ADDR_W  = $clog2(NUM_SLOTS);
  localparam int ID_W    = 16;
  localparam int TIME_W  = 16;
  localparam int CLS_W   = 2;
  localparam int TOTAL_W = 6;
  localparam int ENTRY_W = ID_W + TIME_W;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Class codes
  localparam logic [CLS_W-1:0] CLS_HIGH = 2'd0;
  localparam logic [CLS_W-1:0] CLS_MED  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_LOW  = 2'd2;
  localparam logic [CLS_W-1:0] CLS_NONE = 2'd3;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STS_ENQUEUED = 2'd0,
    STS_DEQUEUED = 2'd1,
    STS_EMPTY    = 2'd2,
    STS_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_t;

  // Classified command from the front
  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [CLS_W-1:0]  cls;
    logic [TIME_W-1:0] tm;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    id;
    logic [CLS_W-1:0]   cls;
    logic [TIME_W-1:0]  tm;
    logic [TOTAL_W-1:0] total;
  } res_t;

  // Advance a ring pointer with wrap at the class depth
  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
    bump = (ptr == PTR_W'(CLASS_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  // Flat slot address of a class ring entry
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLS_W-1:0] cls,
                                                  input logic [PTR_W-1:0] ptr);
    slot_addr = ADDR_W'(cls) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(ptr);
  endfunction

endpackage

@@ hw/rtl/three_class_priority_queue.sv @@
// Three-class strict priority ready queue, FIFO order within each class.
// An enqueue or empty dequeue result is registered as the back end takes the
// command; a dequeue with data waits for the registered entry memory read.
// Throughput: one enqueue per cycle while results are popped at once; a dequeue
// with data stalls later commands until its read is done. A 2-deep command
// queue lets input run ahead. Synchronous reset empties all classes at once.
`timescale 1ns / 1ps
module three_class_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        func,
  input  logic [15:0] proc_id,
  input  logic [1:0]  prio_class,
  input  logic [15:0] run_time,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [15:0] out_id,
  output logic [1:0]  out_class,
  output logic [15:0] out_time,
  output logic [5:0]  total_count
);
  import tpq_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t front_cmd;
  cmd_t back_cmd;
  logic cmd_valid;
  logic cmd_pop;
  logic res_valid;
  res_t res;

  tpq_front u_front (
    .push       (push),
    .full       (full),
    .func       (func),
    .proc_id    (proc_id),
    .prio_class (prio_class),
    .run_time   (run_time),
    .q_full     (q_full),
    .q_push     (q_push),
    .cmd        (front_cmd)
  );

  tpq_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .cmd_in  (front_cmd),
    .full    (q_full),
    .pop     (cmd_pop),
    .cmd_out (back_cmd),
    .valid   (cmd_valid)
  );

  tpq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  // Drive result ports from the result register
  assign empty       = !res_valid;
  assign status      = res.status;
  assign out_id      = res.id;
  assign out_class   = res.cls;
  assign out_time    = res.tm;
  assign total_count = res.total;

endmodule

@@ hw/rtl/tpq_front.sv @@
// Front end: accepts input transactions and classifies them into commands.
// Depends on tpq_pkg; feeds tpq_cmdq.
`timescale 1ns / 1ps
module tpq_front (
  input  logic             push,
  output logic             full,
  input  logic             func,
  input  logic [15:0]      proc_id,
  input  logic [1:0]       prio_class,
  input  logic [15:0]      run_time,
  input  logic             q_full,
  output logic             q_push,
  output tpq_pkg::cmd_t    cmd
);
  import tpq_pkg::*;

  // Refuse input while the command queue has no room
  assign full   = q_full;
  assign q_push = push && !q_full;

  // Build the command; the unused class code falls into low priority
  always_comb begin
    cmd.op  = op_t'(func);
    cmd.id  = proc_id;
    cmd.tm  = run_time;
    cmd.cls = (prio_class == CLS_NONE) ? CLS_LOW : prio_class;
  end

endmodule

@@ hw/rtl/tpq_cmdq.sv @@
// Short command queue that decouples the front end from the back end.
// Depends on tpq_pkg.
`timescale 1ns / 1ps
module tpq_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tpq_pkg::cmd_t cmd_in,
  output logic          full,
  input  logic          pop,
  output tpq_pkg::cmd_t cmd_out,
  output logic          valid
);
  import tpq_pkg::*;

  cmd_t                  slots [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wptr;
  logic [CMDQ_PTR_W-1:0] rptr;
  logic [CMDQ_CNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign valid   = (count != '0);
  assign cmd_out = slots[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Store the payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= cmd_in;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr + CMDQ_PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr + CMDQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CMDQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CMDQ_CNT_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/tpq_back.sv @@
// Back end: executes enqueue/dequeue commands on the class rings and holds
// the result transaction. Depends on tpq_pkg; owns the entry memory.
`timescale 1ns / 1ps
module tpq_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  tpq_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          res_valid,
  output tpq_pkg::res_t res,
  input  logic          res_pop
);
  import tpq_pkg::*;

  back_state_t        state;
  back_state_t        state_next;
  logic [PTR_W-1:0]   head [NUM_CLASSES];
  logic [PTR_W-1:0]   head_next [NUM_CLASSES];
  logic [PTR_W-1:0]   tail [NUM_CLASSES];
  logic [PTR_W-1:0]   tail_next [NUM_CLASSES];
  logic [CNT_W-1:0]   cnt [NUM_CLASSES];
  logic [CNT_W-1:0]   cnt_next [NUM_CLASSES];
  logic [CLS_W-1:0]   deq_cls;
  logic [CLS_W-1:0]   deq_cls_next;
  logic [ENTRY_W-1:0] mem [NUM_SLOTS];
  logic [ENTRY_W-1:0] rd_data;
  logic               mem_we;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr;
  logic               res_load;
  res_t               res_next;
  logic               can_start;
  logic               found;
  logic [CLS_W-1:0]   sel;
  logic [31:0]        total_after;

  // Result slot is free now or frees at this edge
  assign can_start = !res_valid || res_pop;

  // Highest class that holds an entry
  always_comb begin
    found = 1'b0;
    sel   = CLS_HIGH;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (cnt[c] != '0) begin
        found = 1'b1;
        sel   = CLS_W'(c);
      end
    end
  end

  // Entries held after this transaction
  assign total_after = 32'(cnt_next[0]) + 32'(cnt_next[1]) + 32'(cnt_next[2]);

  // Next state, ring updates and result
  always_comb begin
    state_next   = state;
    head_next    = head;
    tail_next    = tail;
    cnt_next     = cnt;
    deq_cls_next = deq_cls;
    cmd_pop      = 1'b0;
    mem_we       = 1'b0;
    waddr        = slot_addr(cmd.cls, tail[cmd.cls]);
    raddr        = slot_addr(sel, head[sel]);
    res_load     = 1'b0;
    res_next     = '0;
    case (state)
      BK_IDLE: begin
        if (cmd_valid && can_start) begin
          cmd_pop = 1'b1;
          if (cmd.op == OP_ENQ) begin
            res_load = 1'b1;
            if (cnt[cmd.cls] == CNT_W'(CLASS_DEPTH)) begin
              res_next.status = STS_FULL;
            end else begin
              mem_we              = 1'b1;
              tail_next[cmd.cls]  = bump(tail[cmd.cls]);
              cnt_next[cmd.cls]   = cnt[cmd.cls] + CNT_W'(1);
              res_next.status     = STS_ENQUEUED;
            end
          end else if (!found) begin
            res_load        = 1'b1;
            res_next.status = STS_EMPTY;
          end else begin
            head_next[sel] = bump(head[sel]);
            cnt_next[sel]  = cnt[sel] - CNT_W'(1);
            deq_cls_next   = sel;
            state_next     = BK_READ;
          end
        end
      end
      BK_READ: begin
        // Entry word arrives from the memory
        res_load        = 1'b1;
        res_next.status = STS_DEQUEUED;
        res_next.id     = rd_data[ENTRY_W-1:TIME_W];
        res_next.tm     = rd_data[TIME_W-1:0];
        res_next.cls    = deq_cls;
        state_next      = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
    res_next.total = total_after[TOTAL_W-1:0];
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= {cmd.id, cmd.tm};
    end
    rd_data <= mem[raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c] <= '0;
        tail[c] <= '0;
        cnt[c]  <= '0;
      end
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      cnt   <= cnt_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Hold payload of the pending dequeue and the result
  always_ff @(posedge clk) begin
    deq_cls <= deq_cls_next;
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule

@@ hw/rtl/tpq_checker.sv @@
// Port-level checker for the three-class priority queue, bound to the top.
// Depends on tpq_pkg and three_class_priority_queue.
`timescale 1ns / 1ps
module tpq_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  status,
  input logic [15:0] out_id,
  input logic [1:0]  out_class,
  input logic [15:0] out_time,
  input logic [5:0]  total_count
);
  import tpq_pkg::*;

  // Reset drops any waiting result
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // Hold a waiting result until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(out_id)
                          && $stable(out_time) && $stable(total_count)))
    else $error("waiting result changed");

  // Only a dequeue with data carries entry fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != STS_DEQUEUED) |->
      (out_id == '0 && out_class == '0 && out_time == '0))
    else $error("nonzero fields on non-dequeue result");

  // An empty report means nothing is held
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == STS_EMPTY) |-> (total_count == '0))
    else $error("empty status with nonzero count");

  // A dequeued class is a real class
  a_class_valid: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == STS_DEQUEUED) |-> (out_class != CLS_NONE))
    else $error("dequeued entry with unused class code");

endmodule

bind three_class_priority_queue tpq_checker u_tpq_checker (.*);
